// File: rtl/array_search_sort_engine_macros.svh
// Assertion macros for the array search and sort engine checker.
// Used by array_search_sort_engine_chk only.
`ifndef ARRAY_SEARCH_SORT_ENGINE_MACROS_SVH
`define ARRAY_SEARCH_SORT_ENGINE_MACROS_SVH
`define ASE_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASE_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/ase_pkg.sv
// Package for the array search and sort engine: payload types, codes, constants.
// No dependencies.
package ase_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = $clog2(Depth);

  typedef struct packed {
    logic [3:0]  mode;
    logic [10:0] range_low;
    logic [10:0] range_high;
    logic [30:0] operand_value;
    logic [2:0]  compare_kind;
    logic        downward;
    logic [10:0] shift_count;
  } ase_in_t;

  typedef struct packed {
    logic [30:0] read_value;
    logic        found;
    logic [10:0] position;
    logic        status;
  } ase_out_t;

  localparam logic [3:0] MODE_READ = 4'd0;
  localparam logic [3:0] MODE_WRITE = 4'd1;
  localparam logic [3:0] MODE_SWAP = 4'd2;
  localparam logic [3:0] MODE_MAX = 4'd3;
  localparam logic [3:0] MODE_MIN = 4'd4;
  localparam logic [3:0] MODE_SEARCH = 4'd5;
  localparam logic [3:0] MODE_SORT = 4'd6;
  localparam logic [3:0] MODE_REV = 4'd7;
  localparam logic [3:0] MODE_SHIFT = 4'd8;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_GE = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;
  localparam logic [2:0] CMP_LE = 3'd4;
  localparam logic [2:0] CMP_LT = 3'd5;

  localparam logic [1:0] REG_VALUE_LIMIT = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_WAIT1, ST_RD2, ST_WRA, ST_WRB, ST_SCAN_RD, ST_SCAN_CHK,
    ST_SORT_NEXT, ST_SORT_KEY, ST_SORT_RD, ST_SORT_CHK, ST_SORT_PUT, ST_DONE
  } ase_state_t;

  function automatic logic meets(input logic [30:0] e, input logic [2:0] k,
                                 input logic [30:0] v);
    logic r;
    case (k)
      CMP_EQ: r = (e == v);
      CMP_NE: r = (e != v);
      CMP_GE: r = (e >= v);
      CMP_GT: r = (e > v);
      CMP_LE: r = (e <= v);
      CMP_LT: r = (e < v);
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/array_search_sort_engine.sv
// Array search and sort engine.
// One item enters on in_valid/in_ready; one result leaves on out_valid/out_ready.
// Positions 1..1024 map to a synchronous memory (registered read data).
// An item is taken only when idle; the block works on one item at a time.
// Per item: a write goes straight to the result; a read reads its position; a swap
// reads both positions and writes them back exchanged; max/min/search read and check
// each element scanned; shift reads each element and writes it to its shifted position
// if that lies in the store; reverse exchanges each pair; sort per element reads a key,
// compares it with each prefix element, then puts the key. After the output transfer
// the block returns to idle. The memory has one read port and one write port.
// The result sits in an output register; it holds until the transfer and the
// next item is taken only after the result is transferred.
// Reset returns the controller to idle and value_limit to its maximum; memory
// contents are undefined until written.
// Config: APB-style write of value_limit at address 0, read returns it.
module array_search_sort_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ase_pkg::ase_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ase_pkg::ase_out_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import ase_pkg::*;

  logic [30:0] mem [Depth];
  logic [30:0] rdata;
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  logic [30:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [30:0] limit_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_VALUE_LIMIT) ? {1'b0, limit_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= '1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_VALUE_LIMIT)
      limit_r <= cfg_pwdata[30:0];
  end

  ase_state_t state_r, state_nxt;
  ase_in_t    it_r, it_nxt;
  ase_out_t   res_r, res_nxt;
  logic [11:0] p_r, p_nxt, q_r, q_nxt, i_r, i_nxt;
  logic [30:0] t_r, t_nxt, best_r, best_nxt;
  logic [30:0] key_r, key_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_data = res_r;

  function automatic logic [AddrW-1:0] ad(input logic [11:0] p);
    logic [11:0] m;
    m = p - 12'd1;
    return m[AddrW-1:0];
  endfunction

  logic [11:0] lo, hi, cnt, n_lo, n_hi;
  logic pos_lo_ok, pos_hi_ok, rng_ok, hit;
  assign lo = {1'b0, it_r.range_low};
  assign hi = {1'b0, it_r.range_high};
  assign cnt = {1'b0, it_r.shift_count};
  assign n_lo = {1'b0, in_data.range_low};
  assign n_hi = {1'b0, in_data.range_high};
  assign pos_lo_ok = n_lo >= 12'd1 && n_lo <= 12'(Depth);
  assign pos_hi_ok = n_hi >= 12'd1 && n_hi <= 12'(Depth);
  assign rng_ok = pos_lo_ok && pos_hi_ok && n_lo <= n_hi;
  assign hit = meets(rdata, it_r.compare_kind, it_r.operand_value);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
    it_r <= it_nxt; res_r <= res_nxt; p_r <= p_nxt; q_r <= q_nxt; i_r <= i_nxt;
    t_r <= t_nxt; best_r <= best_nxt; key_r <= key_nxt;
  end

  always_comb begin
    state_nxt = state_r; it_nxt = it_r; res_nxt = res_r; p_nxt = p_r; q_nxt = q_r;
    i_nxt = i_r; t_nxt = t_r; best_nxt = best_r; key_nxt = key_r;
    we = 1'b0; waddr = ad(p_r); wdata = t_r; raddr = ad(p_r);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          it_nxt = in_data;
          res_nxt = '0;
          p_nxt = n_lo; q_nxt = n_hi;
          if (in_data.mode <= MODE_SWAP) begin
            if (!(pos_lo_ok && (in_data.mode != MODE_SWAP || pos_hi_ok))) begin
              res_nxt.status = 1'b1; state_nxt = ST_DONE;
            end else if (in_data.mode == MODE_WRITE) begin
              we = 1'b1; waddr = ad(n_lo); wdata = in_data.operand_value;
              state_nxt = ST_DONE;
            end else begin
              raddr = ad(n_lo); state_nxt = ST_RD1;
            end
          end else if (in_data.mode <= MODE_SHIFT) begin
            if (!rng_ok) begin
              res_nxt.status = 1'b1; state_nxt = ST_DONE;
            end else begin
              best_nxt = (in_data.mode == MODE_MAX) ? 31'd0 : limit_r;
              case (in_data.mode)
                MODE_MAX: res_nxt.position = in_data.range_low;
                MODE_MIN: res_nxt.position = in_data.range_low;
                MODE_SEARCH: p_nxt = in_data.downward ? n_hi : n_lo;
                MODE_SORT: begin i_nxt = n_lo; end
                MODE_SHIFT: begin
                  p_nxt = in_data.downward ? n_lo : n_hi;
                end
                default: ;
              endcase
              state_nxt = (in_data.mode == MODE_SORT) ? ST_SORT_NEXT : ST_SCAN_RD;
            end
          end else state_nxt = ST_DONE;
        end
      end
      ST_RD1: begin
        t_nxt = rdata;
        if (it_r.mode == MODE_READ) begin
          res_nxt.read_value = rdata; state_nxt = ST_DONE;
        end else begin
          raddr = ad(q_r); state_nxt = ST_RD2;
        end
      end
      ST_RD2: begin
        we = 1'b1; waddr = ad(p_r); wdata = rdata; state_nxt = ST_WRB;
      end
      ST_WRB: begin
        we = 1'b1; waddr = ad(q_r); wdata = t_r;
        if (it_r.mode == MODE_REV) begin
          p_nxt = p_r + 12'd1; q_nxt = q_r - 12'd1; state_nxt = ST_SCAN_RD;
        end else state_nxt = ST_DONE;
      end
      ST_SCAN_RD: begin
        case (it_r.mode)
          MODE_REV: begin
            if (p_r < q_r) begin raddr = ad(p_r); state_nxt = ST_RD1; end
            else state_nxt = ST_DONE;
          end
          MODE_SEARCH: begin
            if (it_r.downward ? (p_r < lo || p_r == 12'd0) : (p_r > hi)) begin
              res_nxt.position = p_r[10:0]; state_nxt = ST_DONE;
            end else begin raddr = ad(p_r); state_nxt = ST_SCAN_CHK; end
          end
          MODE_SHIFT: begin
            if (it_r.downward ? (p_r > hi) : (p_r < lo)) state_nxt = ST_DONE;
            else begin raddr = ad(p_r); state_nxt = ST_SCAN_CHK; end
          end
          default: begin
            if (p_r > hi) state_nxt = ST_DONE;
            else begin raddr = ad(p_r); state_nxt = ST_SCAN_CHK; end
          end
        endcase
      end
      ST_SCAN_CHK: begin
        state_nxt = ST_SCAN_RD;
        case (it_r.mode)
          MODE_SEARCH: begin
            if (hit) begin
              res_nxt.found = 1'b1; res_nxt.position = p_r[10:0]; state_nxt = ST_DONE;
            end else p_nxt = it_r.downward ? p_r - 12'd1 : p_r + 12'd1;
          end
          MODE_SHIFT: begin
            if (it_r.downward) begin
              if (p_r >= cnt + 12'd1) begin
                we = 1'b1; waddr = ad(p_r - cnt); wdata = rdata;
              end
              p_nxt = p_r + 12'd1;
            end else begin
              if (p_r + cnt <= 12'(Depth)) begin
                we = 1'b1; waddr = ad(p_r + cnt); wdata = rdata;
              end
              p_nxt = p_r - 12'd1;
            end
          end
          default: begin
            if (it_r.mode == MODE_MAX ? (rdata >= best_r) : (rdata <= best_r)) begin
              best_nxt = rdata; res_nxt.position = p_r[10:0];
            end
            p_nxt = p_r + 12'd1;
          end
        endcase
      end
      ST_SORT_NEXT: begin
        if (i_r >= hi) state_nxt = ST_DONE;
        else begin raddr = ad(i_r + 12'd1); state_nxt = ST_SORT_KEY; end
      end
      ST_SORT_KEY: begin
        key_nxt = rdata; p_nxt = lo; state_nxt = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        if (p_r > i_r) begin
          i_nxt = i_r + 12'd1; state_nxt = ST_SORT_NEXT;
        end else begin raddr = ad(p_r); state_nxt = ST_SORT_CHK; end
      end
      ST_SORT_CHK: begin
        if (it_r.downward ? (rdata < key_r) : (rdata > key_r)) begin
          we = 1'b1; waddr = ad(p_r); wdata = key_r;
          key_nxt = rdata;
        end
        p_nxt = p_r + 12'd1;
        state_nxt = (p_r == i_r) ? ST_SORT_PUT : ST_SORT_RD;
      end
      ST_SORT_PUT: begin
        we = 1'b1; waddr = ad(i_r + 12'd1); wdata = key_r;
        i_nxt = i_r + 12'd1; state_nxt = ST_SORT_NEXT;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/array_search_sort_engine_chk.sv
// Port checker for the array search and sort engine, bound to the top level.
// Depends on ase_pkg and array_search_sort_engine_macros.svh.
`include "array_search_sort_engine_macros.svh"
module array_search_sort_engine_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ase_pkg::ase_out_t out_data
);
  import ase_pkg::*;
  `ASE_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
  `ASE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASE_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASE_ASSERT_IMPL(a_stat, clk, rst_n, out_valid && out_data.status,
                   !out_data.found && out_data.read_value == 31'd0)
endmodule

bind array_search_sort_engine array_search_sort_engine_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: tb/tb_array_search_sort_engine.sv
// Testbench for array_search_sort_engine: directed and random operations on the element
// store, checked against an in-bench model of the store and of value_limit.
// Depends on ase_pkg and the array_search_sort_engine RTL.
`timescale 1ns / 1ps

import ase_pkg::*;

class array_scoreboard;
  bit [30:0] elements [1:Depth];
  bit        written [1:Depth];
  bit [30:0] limit;
  ase_out_t  pending_results [$];
  int        errors;

  function new();
    limit = '1;
    errors = 0;
    foreach (written[p]) written[p] = 1'b0;
  endfunction

  function bit pos_ok(int p);
    return p >= 1 && p <= Depth;
  endfunction

  function bit [30:0] get_el(int p);
    if (pos_ok(p)) return elements[p];
    return '0;
  endfunction

  function void put_el(int p, bit [30:0] v);
    if (pos_ok(p)) begin
      elements[p] = v;
      written[p] = 1'b1;
    end
  endfunction

  function bit compare_hit(bit [30:0] e, bit [2:0] k, bit [30:0] v);
    case (k)
      CMP_EQ: return e == v;
      CMP_NE: return e != v;
      CMP_GE: return e >= v;
      CMP_GT: return e > v;
      CMP_LE: return e <= v;
      CMP_LT: return e < v;
      default: return 1'b0;
    endcase
  endfunction

  function void shift_up(int lo, int hi, int cnt);
    for (int k = 0; k <= hi - lo; k++) begin
      if (hi + cnt - k <= Depth) put_el(hi + cnt - k, get_el(hi - k));
    end
  endfunction

  function void shift_down(int lo, int hi, int cnt);
    for (int k = 0; k <= hi - lo; k++) begin
      if (lo + k >= cnt + 1) put_el(lo + k - cnt, get_el(lo + k));
    end
  endfunction

  function void insertion_sort(int lo, int hi, bit desc);
    bit [30:0] v;
    int r;
    for (int i = lo; i < hi; i++) begin
      v = get_el(i + 1);
      r = 0;
      for (int x = lo; x <= i; x++) begin
        if (compare_hit(get_el(x), desc ? CMP_LT : CMP_GT, v)) begin
          r = x;
          break;
        end
      end
      if (r != 0) begin
        shift_up(r, i, 1);
        put_el(r, v);
      end
    end
  endfunction

  function ase_out_t apply_op(ase_in_t it);
    ase_out_t res;
    int lo, hi, r;
    bit [30:0] best, e, t;
    bit range_ok;
    res = '0;
    lo = it.range_low;
    hi = it.range_high;
    range_ok = pos_ok(lo) && pos_ok(hi) && lo <= hi;
    if (it.mode <= MODE_SWAP) begin
      if (!pos_ok(lo) || (it.mode == MODE_SWAP && !pos_ok(hi))) begin
        res.status = 1'b1;
      end else if (it.mode == MODE_READ) begin
        res.read_value = get_el(lo);
      end else if (it.mode == MODE_WRITE) begin
        put_el(lo, it.operand_value);
      end else begin
        t = get_el(lo);
        put_el(lo, get_el(hi));
        put_el(hi, t);
      end
    end else if (it.mode <= MODE_SHIFT) begin
      if (!range_ok) begin
        res.status = 1'b1;
      end else if (it.mode == MODE_MAX || it.mode == MODE_MIN) begin
        best = (it.mode == MODE_MAX) ? 31'd0 : limit;
        res.position = 11'(lo);
        for (int x = lo; x <= hi; x++) begin
          e = get_el(x);
          if (it.mode == MODE_MAX ? (e >= best) : (e <= best)) begin
            best = e;
            res.position = 11'(x);
          end
        end
      end else if (it.mode == MODE_SEARCH) begin
        r = it.downward ? lo - 1 : hi + 1;
        if (it.downward) begin
          for (int x = hi; x >= lo; x--) begin
            if (compare_hit(get_el(x), it.compare_kind, it.operand_value)) begin
              r = x;
              res.found = 1'b1;
              break;
            end
          end
        end else begin
          for (int x = lo; x <= hi; x++) begin
            if (compare_hit(get_el(x), it.compare_kind, it.operand_value)) begin
              r = x;
              res.found = 1'b1;
              break;
            end
          end
        end
        res.position = 11'(r);
      end else if (it.mode == MODE_SORT) begin
        insertion_sort(lo, hi, it.downward);
      end else if (it.mode == MODE_REV) begin
        for (int i = lo, j = hi; i < j; i++, j--) begin
          t = get_el(i);
          put_el(i, get_el(j));
          put_el(j, t);
        end
      end else if (it.downward) begin
        shift_down(lo, hi, it.shift_count);
      end else begin
        shift_up(lo, hi, it.shift_count);
      end
    end
    return res;
  endfunction

  function void note_input(ase_in_t it);
    pending_results.push_back(apply_op(it));
  endfunction

  function void check_result(ase_out_t got);
    ase_out_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.read_value !== exp.read_value) begin
      $display("%0t: read_value expected %h actual %h", $time, exp.read_value, got.read_value);
      errors++;
    end
    if (got.found !== exp.found) begin
      $display("%0t: found expected %b actual %b", $time, exp.found, got.found);
      errors++;
    end
    if (got.position !== exp.position) begin
      $display("%0t: position expected %0d actual %0d", $time, exp.position, got.position);
      errors++;
    end
    if (got.status !== exp.status) begin
      $display("%0t: status expected %b actual %b", $time, exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_array_search_sort_engine;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  ase_in_t     in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ase_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  array_scoreboard sb;
  int results_seen = 0;

  array_search_sort_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("array_search_sort_engine test failed");
    $finish;
  end

  function automatic int draw_gap(int n);
    if ((n / 40) % 3 == 2) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic send_item(ase_in_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic write_limit(bit [31:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(REG_VALUE_LIMIT * 4);
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.limit = v[30:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic ase_in_t mk(bit [3:0] m, int lo, int hi, bit [30:0] v,
                                 bit [2:0] k, bit dn, int cnt);
    ase_in_t it;
    it.mode = m;
    it.range_low = 11'(lo);
    it.range_high = 11'(hi);
    it.operand_value = v;
    it.compare_kind = k;
    it.downward = dn;
    it.shift_count = 11'(cnt);
    return it;
  endfunction

  function automatic bit [30:0] draw_value();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 7));
      1: return '0;
      2: return '1;
      default: return 31'($urandom);
    endcase
  endfunction

  // Keep every read inside written entries; fall back to filling the first hole.
  function automatic ase_in_t legalize(ase_in_t it);
    int lo, hi, first, last;
    lo = it.range_low;
    hi = it.range_high;
    first = 1;
    last = 0;
    if (it.mode == MODE_READ && sb.pos_ok(lo)) begin
      first = lo;
      last = lo;
    end else if (it.mode == MODE_SWAP && sb.pos_ok(lo) && sb.pos_ok(hi)) begin
      if (!sb.written[lo]) return mk(MODE_WRITE, lo, hi, draw_value(), it.compare_kind, 0, 0);
      first = hi;
      last = hi;
    end else if (it.mode >= MODE_MAX && it.mode <= MODE_SHIFT && sb.pos_ok(lo) &&
                 sb.pos_ok(hi) && lo <= hi) begin
      first = lo;
      last = hi;
    end
    for (int p = first; p <= last; p++) begin
      if (!sb.written[p]) begin
        it.mode = MODE_WRITE;
        it.range_low = 11'(p);
        it.operand_value = draw_value();
        return it;
      end
    end
    return it;
  endfunction

  function automatic ase_in_t draw_item();
    ase_in_t it;
    int base, lo, span, sel;
    it = ase_in_t'({$urandom, $urandom, 8'($urandom)});
    sel = $urandom_range(0, 99);
    if (sel < 25) it.mode = MODE_WRITE;
    else if (sel < 35) it.mode = MODE_READ;
    else if (sel < 42) it.mode = MODE_SWAP;
    else if (sel < 50) it.mode = MODE_MAX;
    else if (sel < 58) it.mode = MODE_MIN;
    else if (sel < 72) it.mode = MODE_SEARCH;
    else if (sel < 80) it.mode = MODE_SORT;
    else if (sel < 87) it.mode = MODE_REV;
    else if (sel < 97) it.mode = MODE_SHIFT;
    else it.mode = 4'($urandom_range(9, 15));
    it.operand_value = draw_value();
    it.shift_count = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 8));
    if ($urandom_range(0, 99) < 8) begin
      it.range_low = 11'($urandom);
      it.range_high = ($urandom_range(0, 1) == 0) ? 11'($urandom) : 11'(0);
    end else begin
      base = ($urandom_range(0, 4) == 0) ? Depth - 47 : 1;
      lo = base + $urandom_range(0, 47);
      span = (it.mode == MODE_SORT && $urandom_range(0, 7) != 0) ? 12 : 47;
      it.range_low = 11'(lo);
      if (it.mode == MODE_SWAP) it.range_high = 11'(base + $urandom_range(0, 47));
      else it.range_high = 11'(((lo + $urandom_range(0, span)) > base + 47) ?
                                base + 47 : lo + $urandom_range(0, span));
    end
    return legalize(it);
  endfunction

  always begin
    int gap;
    @(negedge clk);
    gap = (results_seen == 150) ? 300 : draw_gap(results_seen);
    if (gap > 0) begin
      out_ready <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && rst_n));
    sb.check_result(out_data);
    results_seen++;
  end

  initial begin
    ase_in_t dir [$];
    int n, guard;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dir.push_back(mk(MODE_WRITE, 1, 0, 31'd0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_WRITE, 2, 0, '1, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_WRITE, 3, 0, 31'd5, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_WRITE, Depth, 0, '1, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_WRITE, Depth - 1, 0, 31'd0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_READ, 2, 0, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_READ, 0, 0, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_WRITE, Depth + 1, 0, '1, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_SWAP, 1, Depth, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_SWAP, 2, 2047, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_MAX, 1, 3, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_MIN, 1, 3, '0, CMP_EQ, 0, 0));
    for (int k = 0; k < 8; k++) dir.push_back(mk(MODE_SEARCH, 1, 3, 31'd5, 3'(k), k[0], 0));
    dir.push_back(mk(MODE_SORT, 1, 3, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_SORT, 1, 3, '0, CMP_EQ, 1, 0));
    dir.push_back(mk(MODE_REV, Depth - 1, Depth, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(MODE_SHIFT, Depth - 1, Depth, '0, CMP_EQ, 0, 1));
    dir.push_back(mk(MODE_SHIFT, 1, 3, '0, CMP_EQ, 1, 2));
    dir.push_back(mk(MODE_MAX, 3, 2, '0, CMP_EQ, 0, 0));
    dir.push_back(mk(4'd15, 1, 3, '0, CMP_EQ, 0, 0));
    foreach (dir[i]) send_item(dir[i], draw_gap(i));

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      drain();
      case (ph)
        0: write_limit(32'h0);
        1: write_limit({1'b1, 31'($urandom_range(0, 7))});
        2: write_limit(32'h7fff_ffff);
        default: write_limit($urandom);
      endcase
      for (int i = 0; i < 140; i++) begin
        send_item(draw_item(), draw_gap(n));
        n++;
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("array_search_sort_engine test passed");
    end else begin
      $display("array_search_sort_engine test failed");
    end
    $finish;
  end
endmodule

// File: array_search_sort_engine.f
+incdir+rtl
rtl/ase_pkg.sv
rtl/array_search_sort_engine.sv
rtl/array_search_sort_engine_chk.sv
tb/tb_array_search_sort_engine.sv
